// ----- rtl/cst_pkg.sv -----
`default_nettype none

package cst_pkg;

  // Longest token, including room for the end marker
  localparam int TOKEN_LIMIT = 8192;
  // Width of the saturating line counter
  localparam int LINE_BITS = 20;

  localparam int LEN_W = $clog2(TOKEN_LIMIT);
  localparam int LC_W = 20;

  // At most three results come from one item
  localparam int MAX_RES = 3;
  localparam int RES_IDX_W = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    LS_SKIP,
    LS_SLASH,
    LS_LINE,
    LS_BLOCK,
    LS_STAR,
    LS_QUOTE,
    LS_WORD
  } lex_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       allow_breaks;
  } in_t;

  typedef struct packed {
    logic [7:0]      token_char;
    logic            char_valid;
    logic            token_end;
    logic            token_was_empty;
    logic            truncated;
    logic [LC_W-1:0] line_count;
  } res_t;

  // All results of one item
  typedef struct packed {
    logic [RES_IDX_W-1:0]  cnt;
    res_t [MAX_RES-1:0]    res;
  } bundle_t;

endpackage

`default_nettype wire

// ----- rtl/cst_front.sv -----
`default_nettype none

module cst_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire cst_pkg::in_t    text,
  output cst_pkg::bundle_t     bundle,
  output logic                 bundle_push
);

  typedef struct packed {
    cst_pkg::lex_state_t              state;
    logic [cst_pkg::LEN_W-1:0]        len;
    logic [cst_pkg::LINE_BITS-1:0]    lines;
    logic                             emit;
    cst_pkg::res_t                    rec;
  } sb_t;

  cst_pkg::lex_state_t           state, state_next;
  logic [cst_pkg::LEN_W-1:0]     len, len_next;
  logic [cst_pkg::LINE_BITS-1:0] lines, lines_next;
  sb_t                           sb;

  function automatic logic [cst_pkg::LC_W-1:0] lc(input logic [cst_pkg::LINE_BITS-1:0] l);
    logic [cst_pkg::LINE_BITS+cst_pkg::LC_W-1:0] w;
    w = (cst_pkg::LINE_BITS + cst_pkg::LC_W)'(l);
    return w[cst_pkg::LC_W-1:0];
  endfunction

  function automatic cst_pkg::res_t mk_char(input logic [7:0] c,
                                            input logic [cst_pkg::LINE_BITS-1:0] l);
    cst_pkg::res_t r;
    r = '0;
    r.token_char = c;
    r.char_valid = 1'b1;
    r.line_count = lc(l);
    return r;
  endfunction

  function automatic cst_pkg::res_t mk_end(input logic empty, input logic trunc,
                                           input logic [cst_pkg::LINE_BITS-1:0] l);
    cst_pkg::res_t r;
    r = '0;
    r.token_end       = 1'b1;
    r.token_was_empty = empty;
    r.truncated       = trunc;
    r.line_count      = lc(l);
    return r;
  endfunction

  // Handling of a byte that may open a new token
  function automatic sb_t start_byte(input logic [7:0] c, input logic allow,
                                     input logic [cst_pkg::LINE_BITS-1:0] l);
    sb_t s;
    logic [cst_pkg::LINE_BITS-1:0] l2;
    s = '0;
    s.state = cst_pkg::LS_SKIP;
    s.lines = l;
    l2 = (l == '1) ? l : l + cst_pkg::LINE_BITS'(1);
    if (c == cst_pkg::CH_NUL) begin
      s.emit = 1'b1;
      s.rec  = mk_end(1'b1, 1'b0, l);
    end else if (c <= cst_pkg::CH_SPACE) begin
      if (c == cst_pkg::CH_NL) begin
        s.lines = l2;
        if (!allow) begin
          s.emit = 1'b1;
          s.rec  = mk_end(1'b1, 1'b0, l2);
        end
      end
    end else if (c == cst_pkg::CH_SLASH) begin
      s.state = cst_pkg::LS_SLASH;
    end else if (c == cst_pkg::CH_QUOTE) begin
      s.state = cst_pkg::LS_QUOTE;
    end else begin
      s.emit  = 1'b1;
      s.rec   = mk_char(c, l);
      s.len   = cst_pkg::LEN_W'(1);
      s.state = cst_pkg::LS_WORD;
    end
    return s;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic       empty_tok;
    c          = text.ch;
    empty_tok  = (len == '0);
    sb         = start_byte(c, text.allow_breaks, lines);
    state_next = state;
    len_next   = len;
    lines_next = lines;
    bundle     = '0;
    if (text.kind) begin
      state_next = cst_pkg::LS_SKIP;
      len_next   = '0;
      lines_next = '0;
    end else begin
      unique case (state)
        cst_pkg::LS_SLASH: begin
          if (c == cst_pkg::CH_SLASH) begin
            state_next = cst_pkg::LS_LINE;
          end else if (c == cst_pkg::CH_STAR) begin
            state_next = cst_pkg::LS_BLOCK;
          end else if (c == cst_pkg::CH_QUOTE) begin
            bundle.res[0] = mk_char(cst_pkg::CH_SLASH, lines);
            bundle.cnt    = cst_pkg::RES_IDX_W'(1);
            len_next      = cst_pkg::LEN_W'(1);
            state_next    = cst_pkg::LS_QUOTE;
          end else if (c > cst_pkg::CH_SPACE) begin
            bundle.res[0] = mk_char(cst_pkg::CH_SLASH, lines);
            bundle.res[1] = mk_char(c, lines);
            bundle.cnt    = cst_pkg::RES_IDX_W'(2);
            len_next      = cst_pkg::LEN_W'(2);
            state_next    = cst_pkg::LS_WORD;
          end else begin
            // lone slash token closes, byte then read as whitespace
            bundle.res[0] = mk_char(cst_pkg::CH_SLASH, lines);
            bundle.res[1] = mk_end(1'b0, 1'b0, lines);
            bundle.res[2] = sb.rec;
            bundle.cnt    = cst_pkg::RES_IDX_W'(2) + cst_pkg::RES_IDX_W'(sb.emit);
            state_next    = sb.state;
            len_next      = sb.len;
            lines_next    = sb.lines;
          end
        end
        cst_pkg::LS_LINE: begin
          if (c == cst_pkg::CH_NUL) begin
            bundle.res[0] = sb.rec;
            bundle.cnt    = cst_pkg::RES_IDX_W'(sb.emit);
            state_next    = sb.state;
            len_next      = sb.len;
            lines_next    = sb.lines;
          end else if (c == cst_pkg::CH_NL) begin
            state_next = cst_pkg::LS_SKIP;
          end
        end
        cst_pkg::LS_BLOCK: begin
          if (c == cst_pkg::CH_NUL) begin
            bundle.res[0] = sb.rec;
            bundle.cnt    = cst_pkg::RES_IDX_W'(sb.emit);
            state_next    = sb.state;
            len_next      = sb.len;
            lines_next    = sb.lines;
          end else if (c == cst_pkg::CH_STAR) begin
            state_next = cst_pkg::LS_STAR;
          end
        end
        cst_pkg::LS_STAR: begin
          if (c == cst_pkg::CH_NUL) begin
            bundle.res[0] = sb.rec;
            bundle.cnt    = cst_pkg::RES_IDX_W'(sb.emit);
            state_next    = sb.state;
            len_next      = sb.len;
            lines_next    = sb.lines;
          end else if (c == cst_pkg::CH_SLASH) begin
            state_next = cst_pkg::LS_SKIP;
          end else if (c != cst_pkg::CH_STAR) begin
            state_next = cst_pkg::LS_BLOCK;
          end
        end
        cst_pkg::LS_QUOTE: begin
          if (c == cst_pkg::CH_NUL) begin
            bundle.res[0] = mk_end(empty_tok, 1'b0, lines);
            bundle.res[1] = sb.rec;
            bundle.cnt    = cst_pkg::RES_IDX_W'(1) + cst_pkg::RES_IDX_W'(sb.emit);
            state_next    = sb.state;
            len_next      = sb.len;
            lines_next    = sb.lines;
          end else if (c == cst_pkg::CH_QUOTE) begin
            bundle.res[0] = mk_end(empty_tok, 1'b0, lines);
            bundle.cnt    = cst_pkg::RES_IDX_W'(1);
            len_next      = '0;
            state_next    = cst_pkg::LS_SKIP;
          end else if (len >= cst_pkg::LEN_W'(cst_pkg::TOKEN_LIMIT - 2)) begin
            // overflow: byte dropped, rest of string read as plain text
            bundle.res[0] = mk_end(empty_tok, 1'b1, lines);
            bundle.cnt    = cst_pkg::RES_IDX_W'(1);
            len_next      = '0;
            state_next    = cst_pkg::LS_SKIP;
          end else begin
            bundle.res[0] = mk_char(c, lines);
            bundle.cnt    = cst_pkg::RES_IDX_W'(1);
            len_next      = len + cst_pkg::LEN_W'(1);
          end
        end
        cst_pkg::LS_WORD: begin
          if (c > cst_pkg::CH_SPACE &&
              len < cst_pkg::LEN_W'(cst_pkg::TOKEN_LIMIT - 1)) begin
            bundle.res[0] = mk_char(c, lines);
            bundle.cnt    = cst_pkg::RES_IDX_W'(1);
            len_next      = len + cst_pkg::LEN_W'(1);
          end else begin
            // word ends; the byte is then handled as a possible start of the next token
            bundle.res[0] = mk_end(empty_tok, c > cst_pkg::CH_SPACE, lines);
            bundle.res[1] = sb.rec;
            bundle.cnt    = cst_pkg::RES_IDX_W'(1) + cst_pkg::RES_IDX_W'(sb.emit);
            state_next    = sb.state;
            len_next      = sb.len;
            lines_next    = sb.lines;
          end
        end
        default: begin
          bundle.res[0] = sb.rec;
          bundle.cnt    = cst_pkg::RES_IDX_W'(sb.emit);
          state_next    = sb.state;
          len_next      = sb.len;
          lines_next    = sb.lines;
        end
      endcase
    end
    bundle_push = accept && (bundle.cnt != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cst_pkg::LS_SKIP;
      len   <= '0;
      lines <= '0;
    end else if (accept) begin
      state <= state_next;
      len   <= len_next;
      lines <= lines_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cst_queue.sv -----
`default_nettype none

module cst_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire cst_pkg::bundle_t  wr_data,
  output logic                   full,
  input  wire logic              rd,
  output cst_pkg::bundle_t       rd_data,
  output logic                   empty
);

  cst_pkg::bundle_t            mem [cst_pkg::QUEUE_DEPTH];
  logic [cst_pkg::QPTR_W-1:0]  wptr, rptr;
  logic [cst_pkg::QPTR_W:0]    count;
  logic                        do_wr, do_rd;

  assign full    = (count == (cst_pkg::QPTR_W + 1)'(cst_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + cst_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
        rptr <= rptr + cst_pkg::QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (cst_pkg::QPTR_W + 1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (cst_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cst_emit.sv -----
`default_nettype none

module cst_emit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cst_pkg::bundle_t  head,
  input  wire logic              head_empty,
  output logic                   head_pop,
  output logic                   empty,
  input  wire logic              pop,
  output cst_pkg::res_t          result
);

  logic [cst_pkg::RES_IDX_W-1:0] idx, idx_next;
  logic                          out_valid, out_valid_next;
  logic                          load;

  assign empty = !out_valid;
  assign load  = !head_empty && (!out_valid || pop);

  always_comb begin
    idx_next       = idx;
    head_pop       = 1'b0;
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
      if (idx == head.cnt - cst_pkg::RES_IDX_W'(1)) begin
        idx_next = '0;
        head_pop = 1'b1;
      end else begin
        idx_next = idx + cst_pkg::RES_IDX_W'(1);
      end
    end else if (pop) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= head.res[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/comment_skipping_tokenizer.sv -----
`default_nettype none

// Channel   Handshake          Payload           Moves
// text      push / full        cst_pkg::in_t     one text byte or session restart per item
// result    pop / empty        cst_pkg::res_t    one token character or end marker per item
//
// Cycles: a byte is lexed in the cycle it is taken; its 0..3 results, if any, enter a
//   4-deep queue as one entry and leave one per cycle from the output register while
//   pop is held. Sustained rate is one byte per cycle while bytes give at most one
//   result each; a byte giving more results holds the output side until all have left.
// Reset: rst (sync, high) clears lexer state, line count, queue and the output valid flag.
// Stalls: full rises only when the queue is full; the lexer and the output side
//   stall on their own, the queue taking up the slack between them.

module comment_skipping_tokenizer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire cst_pkg::in_t   text,
  output logic                empty,
  input  wire logic           pop,
  output cst_pkg::res_t       result
);

  cst_pkg::bundle_t bundle;
  cst_pkg::bundle_t head;
  logic             bundle_push;
  logic             head_empty;
  logic             head_pop;
  logic             accept;

  // bytes are taken whenever the queue has room, even ones giving no result
  assign accept = push && !full;

  // front: lexer state machine, line counter, result assembly
  cst_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text        (text),
    .bundle      (bundle),
    .bundle_push (bundle_push)
  );

  // decoupling queue, one entry per byte that gave results
  cst_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (bundle_push),
    .wr_data (bundle),
    .full    (full),
    .rd      (head_pop),
    .rd_data (head),
    .empty   (head_empty)
  );

  // back: serialises each entry into single result items
  cst_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

`default_nettype wire
